### sv/slcd_pkg.sv
// Shared types, command codes and register indexes of the SPI panel command streamer.
// No dependencies; the front end, queue, sequencer, top level and bench refer to it by scoped names.
`timescale 1ns / 1ps

package slcd_pkg;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_WINDOW = 2'd1,
    OP_PIXEL  = 2'd2
  } op_e;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_UPSIDE = 3'd2;
  localparam logic [2:0] REG_MIRROR = 3'd3;
  localparam logic [2:0] REG_INVERT = 3'd4;

  localparam logic [15:0] WIDTH_RESET  = 16'd480;
  localparam logic [15:0] HEIGHT_RESET = 16'd320;

  // Panel command codes.
  localparam logic [7:0] CMD_SWRESET = 8'h01;
  localparam logic [7:0] CMD_SLPOUT  = 8'h11;
  localparam logic [7:0] CMD_PIXFMT  = 8'h3A;
  localparam logic [7:0] CMD_CASET   = 8'h2A;
  localparam logic [7:0] CMD_PASET   = 8'h2B;
  localparam logic [7:0] CMD_RAMWR   = 8'h2C;
  localparam logic [7:0] CMD_MADCTL  = 8'h36;
  localparam logic [7:0] CMD_DISPON  = 8'h29;
  localparam logic [7:0] CMD_INVON   = 8'h21;

  localparam logic [7:0] PIXFMT_18BIT   = 8'h66;
  localparam logic [7:0] MADCTL_WIDE_UD = 8'hE8;
  localparam logic [7:0] MADCTL_WIDE    = 8'h28;
  localparam logic [7:0] MADCTL_TALL_UD = 8'h48;
  localparam logic [7:0] MADCTL_TALL    = 8'h88;
  localparam logic [7:0] MADCTL_MIRROR  = 8'h80;

  localparam logic [6:0] WAIT_SWRESET_MS = 7'd100;
  localparam logic [6:0] WAIT_SLPOUT_MS  = 7'd20;

  localparam int unsigned CountW = 33;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic        upside_down;
    logic        mirror_image;
    logic        invert_colors;
  } cfg_t;

  // One classified operation waiting for the byte sequencer.
  typedef struct packed {
    op_e         kind;
    logic [15:0] xs;
    logic [15:0] xe;
    logic [15:0] ys;
    logic [15:0] ye;
    logic [16:0] dx;
    logic [16:0] dy;
    logic        inverted;
    logic [5:0]  red;
    logic [5:0]  green;
    logic [5:0]  blue;
  } job_t;

endpackage

### sv/slcd_if.sv
// Valid/ready channel interfaces for operation words in and panel byte words out.
// Depends on nothing; used by the front end, the byte sequencer and the top level.
`timescale 1ns / 1ps

interface slcd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] x_start;
  logic [15:0] y_start;
  logic [15:0] x_end;
  logic [15:0] y_end;
  logic [15:0] pixel_rgb565;

  modport source (output valid, operation, x_start, y_start, x_end, y_end, pixel_rgb565,
                  input ready);
  modport sink   (input valid, operation, x_start, y_start, x_end, y_end, pixel_rgb565,
                  output ready);
endinterface

interface slcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic [6:0] wait_after_ms;
  logic       last_of_run;
  logic       area_done;

  modport source (output valid, out_byte, is_data, wait_after_ms, last_of_run, area_done,
                  input ready);
  modport sink   (input valid, out_byte, is_data, wait_after_ms, last_of_run, area_done,
                  output ready);
endinterface

### sv/slcd_front.sv
// Front end: accepts operation words, drops unused codes and builds queue entries.
// Depends on slcd_pkg and slcd_in_if.
`timescale 1ns / 1ps

module slcd_front (
  slcd_in_if.sink        in_i,
  input  logic           full_i,
  output logic           push_o,
  output slcd_pkg::job_t job_o
);

  function automatic logic [5:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4]};
  endfunction

  logic [16:0] dx;
  logic [16:0] dy;

  assign in_i.ready = !full_i;

  // Area extents are formed here so the sequencer only has the multiply left.
  assign dx = {1'b0, in_i.x_end} - {1'b0, in_i.x_start} + 17'd1;
  assign dy = {1'b0, in_i.y_end} - {1'b0, in_i.y_start} + 17'd1;

  always_comb begin
    job_o.kind     = slcd_pkg::op_e'(in_i.operation);
    job_o.xs       = in_i.x_start;
    job_o.xe       = in_i.x_end;
    job_o.ys       = in_i.y_start;
    job_o.ye       = in_i.y_end;
    job_o.dx       = dx;
    job_o.dy       = dy;
    job_o.inverted = (in_i.x_end < in_i.x_start) || (in_i.y_end < in_i.y_start);
    job_o.red      = widen5(in_i.pixel_rgb565[15:11]);
    job_o.green    = in_i.pixel_rgb565[10:5];
    job_o.blue     = widen5(in_i.pixel_rgb565[4:0]);
  end

  // An unused operation code is taken and discarded.
  always_comb begin
    case (slcd_pkg::op_e'(in_i.operation))
      slcd_pkg::OP_INIT,
      slcd_pkg::OP_WINDOW,
      slcd_pkg::OP_PIXEL: push_o = in_i.valid && !full_i;
      default:            push_o = 1'b0;
    endcase
  end

endmodule

### sv/slcd_queue.sv
// Two-entry queue of classified operations between front end and byte sequencer.
// Depends on slcd_pkg.
`timescale 1ns / 1ps

module slcd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  slcd_pkg::job_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output slcd_pkg::job_t pop_data_o
);

  slcd_pkg::job_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign empty_o    = count_q == 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### sv/slcd_back.sv
// Byte sequencer: walks each queued operation byte by byte into the output register.
// Holds the pixel counter. Depends on slcd_pkg and slcd_out_if.
`timescale 1ns / 1ps

module slcd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  slcd_pkg::cfg_t cfg_i,
  input  slcd_pkg::job_t job_i,
  input  logic           empty_i,
  output logic           pop_o,
  slcd_out_if.source     out_o
);

  logic [4:0]                    idx_q, idx_d;
  logic [slcd_pkg::CountW-1:0]   cnt_q, cnt_d;
  logic                          valid_q;
  logic [7:0]                    byte_q;
  logic                          data_q;
  logic [6:0]                    wait_q;
  logic                          last_q;
  logic                          done_q;

  logic        advance;
  logic        fire;
  logic [7:0]  nbyte;
  logic        ndata;
  logic [6:0]  nwait;
  logic        nlast;
  logic        ndone;
  logic [15:0] wm1;
  logic [15:0] hm1;
  logic [7:0]  orient;
  logic [33:0] area;

  assign advance = !valid_q || out_o.ready;
  assign fire    = advance && !empty_i;
  assign pop_o   = fire && nlast;

  assign wm1  = cfg_i.width - 16'd1;
  assign hm1  = cfg_i.height - 16'd1;
  assign area = job_i.dx * job_i.dy;

  always_comb begin
    if (cfg_i.width > cfg_i.height) begin
      orient = cfg_i.upside_down ? slcd_pkg::MADCTL_WIDE_UD : slcd_pkg::MADCTL_WIDE;
    end else begin
      orient = cfg_i.upside_down ? slcd_pkg::MADCTL_TALL_UD : slcd_pkg::MADCTL_TALL;
    end
    if (cfg_i.mirror_image) begin
      orient = orient ^ slcd_pkg::MADCTL_MIRROR;
    end
  end

  always_comb begin
    nbyte = 8'h00;
    ndata = 1'b1;
    nwait = 7'd0;
    nlast = 1'b0;
    ndone = 1'b0;
    idx_d = idx_q + 5'd1;
    cnt_d = cnt_q;
    case (job_i.kind)
      slcd_pkg::OP_INIT: begin
        if (idx_q == 5'd0) begin
          cnt_d = '0;
        end
        case (idx_q)
          5'd0: begin
            nbyte = slcd_pkg::CMD_SWRESET;
            ndata = 1'b0;
            nwait = slcd_pkg::WAIT_SWRESET_MS;
          end
          5'd1: begin
            nbyte = slcd_pkg::CMD_SLPOUT;
            ndata = 1'b0;
            nwait = slcd_pkg::WAIT_SLPOUT_MS;
          end
          5'd2: begin
            nbyte = slcd_pkg::CMD_PIXFMT;
            ndata = 1'b0;
          end
          5'd3: nbyte = slcd_pkg::PIXFMT_18BIT;
          5'd4: begin
            nbyte = slcd_pkg::CMD_CASET;
            ndata = 1'b0;
          end
          5'd7:  nbyte = wm1[15:8];
          5'd8:  nbyte = wm1[7:0];
          5'd9: begin
            nbyte = slcd_pkg::CMD_PASET;
            ndata = 1'b0;
          end
          5'd12: nbyte = hm1[15:8];
          5'd13: nbyte = hm1[7:0];
          5'd14: begin
            nbyte = slcd_pkg::CMD_MADCTL;
            ndata = 1'b0;
          end
          5'd15: nbyte = orient;
          5'd16: begin
            nbyte = slcd_pkg::CMD_SLPOUT;
            ndata = 1'b0;
          end
          5'd17: begin
            nbyte = slcd_pkg::CMD_DISPON;
            ndata = 1'b0;
            nlast = !cfg_i.invert_colors;
          end
          5'd18: begin
            nbyte = slcd_pkg::CMD_INVON;
            ndata = 1'b0;
            nlast = 1'b1;
          end
          default: nbyte = 8'h00;
        endcase
      end
      slcd_pkg::OP_WINDOW: begin
        // The area size is taken once, while the column command goes out.
        if (idx_q == 5'd0) begin
          cnt_d = job_i.inverted ? '0 : area[slcd_pkg::CountW-1:0];
        end
        case (idx_q)
          5'd0: begin
            nbyte = slcd_pkg::CMD_CASET;
            ndata = 1'b0;
          end
          5'd1: nbyte = job_i.xs[15:8];
          5'd2: nbyte = job_i.xs[7:0];
          5'd3: nbyte = job_i.xe[15:8];
          5'd4: nbyte = job_i.xe[7:0];
          5'd5: begin
            nbyte = slcd_pkg::CMD_PASET;
            ndata = 1'b0;
          end
          5'd6: nbyte = job_i.ys[15:8];
          5'd7: nbyte = job_i.ys[7:0];
          5'd8: nbyte = job_i.ye[15:8];
          5'd9: nbyte = job_i.ye[7:0];
          default: begin
            nbyte = slcd_pkg::CMD_RAMWR;
            ndata = 1'b0;
            nlast = 1'b1;
          end
        endcase
      end
      slcd_pkg::OP_PIXEL: begin
        case (idx_q)
          5'd0: nbyte = {2'b00, job_i.red};
          5'd1: nbyte = {2'b00, job_i.green};
          default: begin
            nbyte = {2'b00, job_i.blue};
            nlast = 1'b1;
            // A count of one means this pixel closes the area.
            ndone = cnt_q == {{(slcd_pkg::CountW-1){1'b0}}, 1'b1};
            if (cnt_q != '0) begin
              cnt_d = cnt_q - {{(slcd_pkg::CountW-1){1'b0}}, 1'b1};
            end
          end
        endcase
      end
      default: nlast = 1'b1;
    endcase
    if (nlast) begin
      idx_d = 5'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 5'd0;
      cnt_q   <= '0;
    end else begin
      if (advance) begin
        valid_q <= !empty_i;
      end
      if (fire) begin
        idx_q <= idx_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= nbyte;
      data_q <= ndata;
      wait_q <= nwait;
      last_q <= nlast;
      done_q <= ndone;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.out_byte      = byte_q;
  assign out_o.is_data       = data_q;
  assign out_o.wait_after_ms = wait_q;
  assign out_o.last_of_run   = last_q;
  assign out_o.area_done     = done_q;

endmodule

### sv/spi_lcd_command_pixel_streamer.sv
// SPI panel command and pixel streamer, top level.
//
// in_i carries operation words (init, window, pixel); out_o carries one panel byte per
// word, tagged command or data, with the wait to observe after it, a flag on the last
// byte of each operation and a flag on the byte that completes a window area.
// The configuration port (cfg_valid_i, cfg_index_i, cfg_data_i) sets panel size,
// orientation and inversion; it is always ready and should only be written when idle.
// An operation word is taken into a two-entry queue in the cycle it is offered while
// the queue has room; unused operation codes are taken and discarded.
// The first byte of an operation is registered in the queue entry and then in the output
// register, which it enters once that register is free.
// The sequencer emits one byte per cycle while out_o accepts, so a pixel is 3 bytes, a window 11
// and an init 18, or 19 with inversion; back-to-back pixels follow one another with no idle gap.
// A stall on out_o holds the current byte in the output register; the queue then
// fills and in_i.ready drops until bytes move again.
// Reset restores the default panel settings (480 by 320, no rotation, mirror or
// inversion), empties the queue and clears the pixel counter.
`timescale 1ns / 1ps

module spi_lcd_command_pixel_streamer (
  input  logic        clk_i,
  input  logic        rst_ni,
  slcd_in_if.sink     in_i,
  slcd_out_if.source  out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  slcd_pkg::cfg_t cfg_q;
  slcd_pkg::job_t push_job;
  slcd_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width         <= slcd_pkg::WIDTH_RESET;
      cfg_q.height        <= slcd_pkg::HEIGHT_RESET;
      cfg_q.upside_down   <= 1'b0;
      cfg_q.mirror_image  <= 1'b0;
      cfg_q.invert_colors <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        slcd_pkg::REG_WIDTH:  cfg_q.width         <= cfg_data_i;
        slcd_pkg::REG_HEIGHT: cfg_q.height        <= cfg_data_i;
        slcd_pkg::REG_UPSIDE: cfg_q.upside_down   <= cfg_data_i[0];
        slcd_pkg::REG_MIRROR: cfg_q.mirror_image  <= cfg_data_i[0];
        slcd_pkg::REG_INVERT: cfg_q.invert_colors <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  slcd_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  slcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .pop_data_o  (head_job)
  );

  slcd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .job_i   (head_job),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

### bench/tb_spi_lcd_command_pixel_streamer.sv
// Self-checking bench for spi_lcd_command_pixel_streamer: runs directed and random operation
// words and checks each panel byte against a predictor kept in step with the block.
// Depends on sv/slcd_pkg.sv, sv/slcd_if.sv and sv/spi_lcd_command_pixel_streamer.sv.
`timescale 1ns / 1ps

module tb_spi_lcd_command_pixel_streamer;

  localparam logic [1:0] OpUnused   = 2'd3;
  localparam int         DrainTail  = 6;
  localparam int         QuietLimit = 1000;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [15:0] rgb;
  } op_word_t;

  typedef struct packed {
    logic [7:0] code;
    logic       is_data;
    logic [6:0] wait_ms;
    logic       last;
    logic       done;
  } panel_byte_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  slcd_in_if  in_ch ();
  slcd_out_if out_ch ();

  spi_lcd_command_pixel_streamer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  slcd_pkg::cfg_t model_cfg;
  logic [32:0]    model_pixels_left;
  panel_byte_t    expected_bytes[$];
  panel_byte_t    run_bytes[$];
  int             error_count;
  int             quiet_cycles;
  int             hold_off_cycles;
  bit             send_no_gaps;
  bit             recv_no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void stage_byte(logic [7:0] code, logic is_data, logic [6:0] wait_ms);
    run_bytes.push_back('{code: code, is_data: is_data, wait_ms: wait_ms,
                          last: 1'b0, done: 1'b0});
  endfunction

  function automatic void stage_range(logic [7:0] cmd, logic [15:0] a, logic [15:0] b);
    stage_byte(cmd, 1'b0, 7'd0);
    stage_byte(a[15:8], 1'b1, 7'd0);
    stage_byte(a[7:0], 1'b1, 7'd0);
    stage_byte(b[15:8], 1'b1, 7'd0);
    stage_byte(b[7:0], 1'b1, 7'd0);
  endfunction

  function automatic void predict_panel_bytes(op_word_t w);
    logic [7:0]  orient;
    logic [16:0] dx;
    logic [16:0] dy;
    logic        area_hit;
    panel_byte_t tail;
    run_bytes.delete();
    area_hit = 1'b0;
    case (w.op)
      slcd_pkg::OP_INIT: begin
        model_pixels_left = '0;
        stage_byte(slcd_pkg::CMD_SWRESET, 1'b0, slcd_pkg::WAIT_SWRESET_MS);
        stage_byte(slcd_pkg::CMD_SLPOUT, 1'b0, slcd_pkg::WAIT_SLPOUT_MS);
        stage_byte(slcd_pkg::CMD_PIXFMT, 1'b0, 7'd0);
        stage_byte(slcd_pkg::PIXFMT_18BIT, 1'b1, 7'd0);
        stage_range(slcd_pkg::CMD_CASET, 16'd0, model_cfg.width - 16'd1);
        stage_range(slcd_pkg::CMD_PASET, 16'd0, model_cfg.height - 16'd1);
        if (model_cfg.width > model_cfg.height) begin
          orient = model_cfg.upside_down ? slcd_pkg::MADCTL_WIDE_UD : slcd_pkg::MADCTL_WIDE;
        end else begin
          orient = model_cfg.upside_down ? slcd_pkg::MADCTL_TALL_UD : slcd_pkg::MADCTL_TALL;
        end
        if (model_cfg.mirror_image) begin
          orient = orient ^ slcd_pkg::MADCTL_MIRROR;
        end
        stage_byte(slcd_pkg::CMD_MADCTL, 1'b0, 7'd0);
        stage_byte(orient, 1'b1, 7'd0);
        stage_byte(slcd_pkg::CMD_SLPOUT, 1'b0, 7'd0);
        stage_byte(slcd_pkg::CMD_DISPON, 1'b0, 7'd0);
        if (model_cfg.invert_colors) begin
          stage_byte(slcd_pkg::CMD_INVON, 1'b0, 7'd0);
        end
      end
      slcd_pkg::OP_WINDOW: begin
        stage_range(slcd_pkg::CMD_CASET, w.x_start, w.x_end);
        stage_range(slcd_pkg::CMD_PASET, w.y_start, w.y_end);
        stage_byte(slcd_pkg::CMD_RAMWR, 1'b0, 7'd0);
        if (w.x_end < w.x_start || w.y_end < w.y_start) begin
          model_pixels_left = '0;
        end else begin
          dx = {1'b0, w.x_end} - {1'b0, w.x_start} + 17'd1;
          dy = {1'b0, w.y_end} - {1'b0, w.y_start} + 17'd1;
          model_pixels_left = {16'd0, dx} * {16'd0, dy};
        end
      end
      slcd_pkg::OP_PIXEL: begin
        // Five-bit channels are widened by repeating their top bit below the LSB.
        stage_byte({2'b00, w.rgb[15:11], w.rgb[15]}, 1'b1, 7'd0);
        stage_byte({2'b00, w.rgb[10:5]}, 1'b1, 7'd0);
        stage_byte({2'b00, w.rgb[4:0], w.rgb[4]}, 1'b1, 7'd0);
        if (model_pixels_left != '0) begin
          model_pixels_left = model_pixels_left - 33'd1;
          area_hit = (model_pixels_left == '0);
        end
      end
      default: begin
      end
    endcase
    if (run_bytes.size() != 0) begin
      tail = run_bytes.pop_back();
      tail.last = 1'b1;
      tail.done = area_hit;
      run_bytes.push_back(tail);
    end
    foreach (run_bytes[i]) expected_bytes.push_back(run_bytes[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_bytes
    panel_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("word with nothing expected", 32'(out_ch.out_byte), 32'd0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_ch.out_byte !== want.code)
          report_mismatch("out_byte", 32'(out_ch.out_byte), 32'(want.code));
        if (out_ch.is_data !== want.is_data)
          report_mismatch("is_data", 32'(out_ch.is_data), 32'(want.is_data));
        if (out_ch.wait_after_ms !== want.wait_ms)
          report_mismatch("wait_after_ms", 32'(out_ch.wait_after_ms), 32'(want.wait_ms));
        if (out_ch.last_of_run !== want.last)
          report_mismatch("last_of_run", 32'(out_ch.last_of_run), 32'(want.last));
        if (out_ch.area_done !== want.done)
          report_mismatch("area_done", 32'(out_ch.area_done), 32'(want.done));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d words still expected",
               $time, quiet_cycles, expected_bytes.size());
      $display("** spi_lcd_command_pixel_streamer: FAILED **");
      $finish;
    end
  end

  // Output side: a random stall, at times none, per word, plus a long hold-off when asked.
  initial begin : byte_sink
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      gap = recv_no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic op_word_t make_word(logic [1:0] op);
    op_word_t w;
    w.op      = op;
    w.x_start = 16'($urandom);
    w.y_start = 16'($urandom);
    w.x_end   = 16'($urandom);
    w.y_end   = 16'($urandom);
    w.rgb     = 16'($urandom);
    return w;
  endfunction

  // Valid is left high after acceptance so that back-to-back words need no fresh rise on it.
  task automatic send_word(op_word_t w);
    int gap;
    gap = send_no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= w.op;
    in_ch.x_start      <= w.x_start;
    in_ch.y_start      <= w.y_start;
    in_ch.x_end        <= w.x_end;
    in_ch.y_end        <= w.y_end;
    in_ch.pixel_rgb565 <= w.rgb;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    predict_panel_bytes(w);
  endtask

  task automatic send_init();
    send_word(make_word(slcd_pkg::OP_INIT));
  endtask

  task automatic send_window(logic [15:0] xs, logic [15:0] ys, logic [15:0] xe,
                             logic [15:0] ye);
    op_word_t w;
    w = make_word(slcd_pkg::OP_WINDOW);
    w.x_start = xs;
    w.y_start = ys;
    w.x_end   = xe;
    w.y_end   = ye;
    send_word(w);
  endtask

  task automatic send_pixel(logic [15:0] rgb);
    op_word_t w;
    w = make_word(slcd_pkg::OP_PIXEL);
    w.rgb = rgb;
    send_word(w);
  endtask

  // Stops offering words and waits for every expected byte, then waits out DrainTail
  // in case the last word was one that produces nothing.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DrainTail) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      slcd_pkg::REG_WIDTH:  model_cfg.width         = data;
      slcd_pkg::REG_HEIGHT: model_cfg.height        = data;
      slcd_pkg::REG_UPSIDE: model_cfg.upside_down   = data[0];
      slcd_pkg::REG_MIRROR: model_cfg.mirror_image  = data[0];
      slcd_pkg::REG_INVERT: model_cfg.invert_colors = data[0];
      default: begin
      end
    endcase
  endtask

  // Only the low bit of the flag registers counts, so the upper bits carry noise.
  task automatic set_panel(logic [15:0] w, logic [15:0] h, logic ud, logic mir, logic inv);
    logic [15:0] noise;
    drain_block();
    noise = 16'($urandom);
    write_reg(slcd_pkg::REG_WIDTH, w);
    write_reg(slcd_pkg::REG_HEIGHT, h);
    write_reg(slcd_pkg::REG_UPSIDE, {noise[15:1], ud});
    write_reg(slcd_pkg::REG_MIRROR, {noise[14:0], mir});
    write_reg(slcd_pkg::REG_INVERT, {noise[13:0], noise[15], inv});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(1, 800));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    send_pixel(16'($urandom));
    send_init();
    send_word(make_word(OpUnused));
    drain_block();
  endtask

  task automatic test_directed_ops();
    send_window(16'd10, 16'd20, 16'd11, 16'd20);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hF800);
    // Areas with an end before their start send the bytes but open nothing.
    send_window(16'd100, 16'd0, 16'd99, 16'd5);
    send_pixel(16'h07E0);
    send_window(16'd0, 16'd7, 16'd3, 16'd6);
    send_pixel(16'h001F);
    // The whole coordinate space needs the top bit of the pixel counter.
    send_window(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hAAAA);
    send_pixel(16'h5555);
    send_init();
    send_pixel(16'h8410);
    send_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h7BEF);
    drain_block();
  endtask

  task automatic test_panel_settings();
    set_panel(16'd0, 16'd0, 1'b1, 1'b0, 1'b1);
    send_init();
    set_panel(16'hFFFF, 16'd1, 1'b0, 1'b1, 1'b0);
    send_init();
    set_panel(16'd1, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    send_init();
    set_panel(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_init();
    set_panel(16'd480, 16'd320, 1'b1, 1'b1, 1'b0);
    send_init();
    set_panel(16'd320, 16'd480, 1'b0, 1'b1, 1'b1);
    send_init();
    drain_block();
  endtask

  task automatic test_output_backpressure();
    int i;
    drain_block();
    send_no_gaps    = 1'b1;
    hold_off_cycles = 90;
    send_window(16'd5, 16'd5, 16'd8, 16'd6);
    for (i = 0; i < 10; i++) send_pixel(16'($urandom));
    send_init();
    send_no_gaps = 1'b0;
    drain_block();
    send_window(16'd0, 16'd0, 16'd0, 16'd1);
    send_pixel(16'($urandom));
    send_pixel(16'($urandom));
    drain_block();
  endtask

  // Mostly well-formed window-then-pixels runs with random content, some cut short,
  // some overrun, mixed with inits and words of any code.
  task automatic test_random_traffic();
    int          counted;
    int          phase;
    int          kind;
    int          dx;
    int          dy;
    int          area;
    int          npix;
    logic [15:0] xs;
    logic [15:0] ys;
    op_word_t    w;
    counted = 0;
    for (phase = 0; phase < 4; phase++) begin
      set_panel(pick_size(), pick_size(), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      while (counted < (phase + 1) * 50) begin
        send_no_gaps = ($urandom_range(0, 3) == 0);
        recv_no_gaps = ($urandom_range(0, 3) == 0);
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          send_init();
          counted++;
        end else if (kind == 1) begin
          w = make_word(2'($urandom_range(0, 3)));
          send_word(w);
          if (w.op != OpUnused) counted++;
        end else begin
          dx = $urandom_range(0, 3);
          dy = $urandom_range(0, 3);
          xs = 16'($urandom_range(1, 65535 - dx));
          ys = 16'($urandom_range(0, 65535 - dy));
          if ($urandom_range(0, 7) == 0) begin
            send_window(xs, ys, xs - 16'd1, ys + 16'(dy));
            area = 0;
          end else begin
            send_window(xs, ys, xs + 16'(dx), ys + 16'(dy));
            area = (dx + 1) * (dy + 1);
          end
          counted++;
          if (area == 0) begin
            npix = $urandom_range(1, 2);
          end else if ($urandom_range(0, 5) == 0) begin
            npix = $urandom_range(1, area);
          end else begin
            npix = area + $urandom_range(0, 1);
          end
          repeat (npix) begin
            send_pixel(16'($urandom));
            counted++;
          end
        end
      end
    end
    send_no_gaps = 1'b0;
    recv_no_gaps = 1'b0;
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= slcd_pkg::OP_INIT;
    in_ch.x_start      <= '0;
    in_ch.y_start      <= '0;
    in_ch.x_end        <= '0;
    in_ch.y_end        <= '0;
    in_ch.pixel_rgb565 <= '0;
    cfg_valid          <= 1'b0;
    cfg_index          <= slcd_pkg::REG_WIDTH;
    cfg_data           <= '0;
    error_count       = 0;
    quiet_cycles      = 0;
    hold_off_cycles   = 0;
    send_no_gaps      = 1'b0;
    recv_no_gaps      = 1'b0;
    model_cfg.width         = slcd_pkg::WIDTH_RESET;
    model_cfg.height        = slcd_pkg::HEIGHT_RESET;
    model_cfg.upside_down   = 1'b0;
    model_cfg.mirror_image  = 1'b0;
    model_cfg.invert_colors = 1'b0;
    model_pixels_left       = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_ops();
    test_panel_settings();
    test_output_backpressure();
    test_random_traffic();
    drain_block();

    if (error_count == 0) begin
      $display("** spi_lcd_command_pixel_streamer: PASSED **");
    end else begin
      $display("** spi_lcd_command_pixel_streamer: FAILED **");
    end
    $finish;
  end

endmodule

### spi_lcd_command_pixel_streamer.f
sv/slcd_pkg.sv
sv/slcd_if.sv
sv/slcd_front.sv
sv/slcd_queue.sv
sv/slcd_back.sv
sv/spi_lcd_command_pixel_streamer.sv
bench/tb_spi_lcd_command_pixel_streamer.sv
